FILE: rtl/thr_pkg.sv
`default_nettype none

package thr_pkg;

    // Field widths fixed by the item formats.
    localparam int unsigned CMD_W       = 3;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned CAP_W       = 9;
    localparam int unsigned FILL_W      = 9;
    localparam int unsigned IN_TDATA_W  = 104;
    localparam int unsigned OUT_TDATA_W = 112;

    // Depth of the record store; the fill and capacity fields are sized for it.
    localparam int unsigned MAX_RECORDS = 256;

    // Command codes carried in the slave-side tuser.
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RESET   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LATEST  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BY_TAG  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_AT_MIN  = 3'd4;

    // Status codes carried in the master-side tuser.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    // Reset value of the capacity register.
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // One stored record.
    typedef struct packed {
        logic        clamp;
        logic [31:0] payload;
        logic [31:0] tag;
        logic [31:0] minute;
    } t_record;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                take;
        logic                clear;
        logic                load_scan;
        logic                scan_run;
        logic                write;
        logic                res_load;
        logic                res_found;
        logic [STATUS_W-1:0] res_status;
        logic                out_load;
    } t_dp_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             held_zero;
        logic             tag_zero;
        logic             pend;
        logic             pend_last;
        logic             match;
        logic             out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/timestamped_history_ring.sv
// Timestamped history ring: a bounded, time-ordered store of records.
// Slave stream: tuser carries the command (append, reset, latest, find by
// tag, find at or before a minute); tdata carries minute, tag, payload and
// the clamp bit. Master stream: one word per command, tuser carries the
// status, tdata the returned record, the sticky clamp flag and the fill.
// The capacity register is written through i_cfg_we / i_cfg_wdata; the
// user must write it only while the block is idle; the block itself does
// not enforce this. Lowering it below the fill drops old records only on
// the next accepted append. The reset command, unknown commands and queries
// on an empty store go from dispatch straight to the result; append first
// reads the newest record (not when empty) and writes unless rejected; a
// search examines records newest first, up to fill of them. The single
// read port of the record memory sets the one-record-per-cycle search
// rate. One item is in work at a time. A result waits in the output
// register while the receiver stalls; the next word is accepted meanwhile
// and its result is held back until the output register frees.
// Reset empties the history and clears the sticky flag; capacity returns
// to 256. The record memory needs no clearing pass.
`default_nettype none

module timestamped_history_ring (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // Fields from bit 0 up: minute[31:0], tag[63:32], payload[95:64],
    // record_clamp[96], zero pad.
    input  wire logic [thr_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // Fields from bit 0 up: command[2:0].
    input  wire logic [thr_pkg::CMD_W-1:0]           i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // Fields from bit 0 up: found_minute[31:0], found_tag[63:32],
    // found_payload[95:64], found_clamp[96], sticky_clamp[97], fill[106:98].
    output logic [thr_pkg::OUT_TDATA_W-1:0]          o_m_axis_tdata,
    // Fields from bit 0 up: status[1:0].
    output logic [thr_pkg::STATUS_W-1:0]             o_m_axis_tuser,
    input  wire logic                                i_cfg_we,
    input  wire logic [thr_pkg::CAP_W-1:0]           i_cfg_wdata
);

    thr_pkg::t_dp_ctrl ctrl;
    thr_pkg::t_dp_stat stat;

    // Sequencer.
    thr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    // Record store, scan pipeline and output register.
    thr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_tdata     (i_s_axis_tdata),
        .i_tuser     (i_s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser)
    );

    // An accepted word closes the input until its result is produced.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while an item is in work");

    // A result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |-> stat.out_free)
        else $error("output register overwritten before it was taken");

    // Rejected appends and misses return an all-zero record.
    a_zero_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == thr_pkg::ST_REJECT ||
                             o_m_axis_tuser == thr_pkg::ST_NOTFOUND))
        |-> (o_m_axis_tdata[96:0] == 97'd0))
        else $error("record fields nonzero without a hit");

    // The reported fill never exceeds the store depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (32'(o_m_axis_tdata[106:98]) <= 32'(thr_pkg::MAX_RECORDS)))
        else $error("fill above store depth");

endmodule

`default_nettype wire

FILE: rtl/thr_dpath.sv
`default_nettype none

module thr_dpath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire thr_pkg::t_dp_ctrl                   i_ctrl,
    output thr_pkg::t_dp_stat                        o_stat,
    // Fields from bit 0 up: minute[31:0], tag[63:32], payload[95:64],
    // record_clamp[96], zero pad.
    input  wire logic [thr_pkg::IN_TDATA_W-1:0]      i_tdata,
    // Fields from bit 0 up: command[2:0].
    input  wire logic [thr_pkg::CMD_W-1:0]           i_tuser,
    input  wire logic                                i_cfg_we,
    input  wire logic [thr_pkg::CAP_W-1:0]           i_cfg_wdata,
    input  wire logic                                i_m_tready,
    output logic                                     o_m_tvalid,
    // Fields from bit 0 up: found_minute[31:0], found_tag[63:32],
    // found_payload[95:64], found_clamp[96], sticky_clamp[97], fill[106:98].
    output logic [thr_pkg::OUT_TDATA_W-1:0]          o_m_tdata,
    // Fields from bit 0 up: status[1:0].
    output logic [thr_pkg::STATUS_W-1:0]             o_m_tuser
);

    localparam int unsigned MAX_RECORDS = thr_pkg::MAX_RECORDS;
    localparam int unsigned IW    = $clog2(MAX_RECORDS);
    localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int unsigned SUM_W = CNT_W + 1;

    // Fold a slot sum that stays below twice the depth back into range.
    function automatic logic [IW-1:0] f_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = s;
        if (s >= SUM_W'(MAX_RECORDS)) begin
            t = s - SUM_W'(MAX_RECORDS);
        end
        return t[IW-1:0];
    endfunction

    // Latched item.
    logic [thr_pkg::CMD_W-1:0] r_cmd;
    logic [31:0]               r_minute;
    logic [31:0]               r_tag;
    logic [31:0]               r_payload;
    logic                      r_rclamp;

    // Ring state and configuration.
    logic [thr_pkg::CAP_W-1:0] r_cap;
    logic [IW-1:0]             r_oldest;
    logic [IW-1:0]             n_oldest;
    logic [CNT_W-1:0]          r_held;
    logic [CNT_W-1:0]          n_held;
    logic                      r_seen;

    // Scan sequencing.
    logic [CNT_W-1:0]          r_scan;
    logic                      r_issue_on;
    logic                      r_single;
    logic                      r_pend;
    logic                      r_pend_last;

    // Record memory and its read register.
    thr_pkg::t_record          r_mem [MAX_RECORDS];
    thr_pkg::t_record          r_rd;
    thr_pkg::t_record          wr_rec;
    logic                      rd_en;
    logic [IW-1:0]             rd_addr;
    logic [IW-1:0]             wr_addr;

    // Result and output registers.
    logic [thr_pkg::STATUS_W-1:0] r_res_status;
    thr_pkg::t_record             r_res_rec;
    logic                         r_out_valid;
    logic [thr_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [thr_pkg::STATUS_W-1:0] r_out_status;

    logic [31:0]      cap32;
    logic [CNT_W-1:0] eff_cap;
    logic [CNT_W-1:0] drop;
    logic [31:0]      held32;
    logic             match;

    // Effective capacity: zero acts as one, large values clip to the depth.
    always_comb begin
        cap32 = 32'(r_cap);
        if (cap32 == 32'd0) begin
            eff_cap = CNT_W'(1);
        end else if (cap32 > 32'(MAX_RECORDS)) begin
            eff_cap = CNT_W'(MAX_RECORDS);
        end else begin
            eff_cap = CNT_W'(cap32);
        end
    end

    // Append bookkeeping: the new slot always follows the newest record.
    always_comb begin
        drop     = r_held - eff_cap + CNT_W'(1);
        wr_addr  = f_wrap(SUM_W'(r_oldest) + SUM_W'(r_held));
        n_oldest = r_oldest;
        n_held   = r_held + CNT_W'(1);
        if (r_held >= eff_cap) begin
            n_oldest = f_wrap(SUM_W'(r_oldest) + SUM_W'(drop));
            n_held   = eff_cap;
        end
        wr_rec.clamp   = r_rclamp;
        wr_rec.payload = r_payload;
        wr_rec.tag     = r_tag;
        wr_rec.minute  = r_minute;
    end

    // Read address walks from the newest record toward the oldest.
    assign rd_en   = i_ctrl.scan_run & r_issue_on;
    assign rd_addr = f_wrap(SUM_W'(r_oldest) + SUM_W'(r_scan));

    // Compare of the record just read against the latched key.
    always_comb begin
        case (r_cmd)
            thr_pkg::CMD_APPEND: match = (r_minute < r_rd.minute);
            thr_pkg::CMD_LATEST: match = 1'b1;
            thr_pkg::CMD_BY_TAG: match = (r_rd.tag == r_tag);
            thr_pkg::CMD_AT_MIN: match = (r_rd.minute <= r_minute);
            default:             match = 1'b0;
        endcase
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.write) begin
            r_mem[wr_addr] <= wr_rec;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Item latch.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_cmd     <= i_tuser;
            r_minute  <= i_tdata[31:0];
            r_tag     <= i_tdata[63:32];
            r_payload <= i_tdata[95:64];
            r_rclamp  <= i_tdata[96];
        end
    end

    // Capacity register, ring pointers and sticky flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= thr_pkg::CAP_RESET;
            r_oldest <= '0;
            r_held   <= '0;
            r_seen   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_ctrl.clear) begin
                r_oldest <= '0;
                r_held   <= '0;
                r_seen   <= 1'b0;
            end else if (i_ctrl.write) begin
                r_oldest <= n_oldest;
                r_held   <= n_held;
                r_seen   <= r_seen | r_rclamp;
            end
        end
    end

    // Scan counter and read pipeline flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_on  <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_single    <= 1'b0;
            r_scan      <= '0;
        end else if (i_ctrl.load_scan) begin
            r_scan      <= r_held - CNT_W'(1);
            r_issue_on  <= 1'b1;
            r_pend      <= 1'b0;
            r_single    <= (r_cmd == thr_pkg::CMD_APPEND) || (r_cmd == thr_pkg::CMD_LATEST);
        end else if (i_ctrl.scan_run) begin
            r_pend      <= rd_en;
            r_pend_last <= (r_scan == '0) | r_single;
            if (rd_en) begin
                if ((r_scan == '0) || r_single) begin
                    r_issue_on <= 1'b0;
                end else begin
                    r_scan <= r_scan - CNT_W'(1);
                end
            end
        end
    end

    // Result capture.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.res_load) begin
            r_res_status <= i_ctrl.res_status;
            r_res_rec    <= i_ctrl.res_found ? r_rd : '0;
        end
    end

    assign held32 = 32'(r_held);

    // Output register toward the master side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out_status <= r_res_status;
            r_out_data   <= {5'd0, held32[thr_pkg::FILL_W-1:0], r_seen, r_res_rec.clamp,
                             r_res_rec.payload, r_res_rec.tag, r_res_rec.minute};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

    // Status toward the controller.
    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.held_zero = (r_held == '0);
        o_stat.tag_zero  = (r_tag == 32'd0);
        o_stat.pend      = r_pend;
        o_stat.pend_last = r_pend_last;
        o_stat.match     = match;
        o_stat.out_free  = !r_out_valid || i_m_tready;
    end

endmodule

`default_nettype wire

FILE: rtl/thr_ctrl.sv
`default_nettype none

module thr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire thr_pkg::t_dp_stat i_stat,
    output thr_pkg::t_dp_ctrl      o_ctrl
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_SCAN     = 5'b00100,
        S_WRITE    = 5'b01000,
        S_FINISH   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_ctrl.take = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.cmd)
                    thr_pkg::CMD_APPEND: begin
                        if (i_stat.held_zero) begin
                            n_state = S_WRITE;
                        end else begin
                            o_ctrl.load_scan = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    thr_pkg::CMD_RESET: begin
                        o_ctrl.clear      = 1'b1;
                        o_ctrl.res_load   = 1'b1;
                        o_ctrl.res_status = thr_pkg::ST_OK;
                        n_state           = S_FINISH;
                    end
                    thr_pkg::CMD_LATEST, thr_pkg::CMD_AT_MIN, thr_pkg::CMD_BY_TAG: begin
                        if (i_stat.held_zero ||
                            (i_stat.cmd == thr_pkg::CMD_BY_TAG && i_stat.tag_zero)) begin
                            o_ctrl.res_load   = 1'b1;
                            o_ctrl.res_status = thr_pkg::ST_NOTFOUND;
                            n_state           = S_FINISH;
                        end else begin
                            o_ctrl.load_scan = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    default: begin
                        o_ctrl.res_load   = 1'b1;
                        o_ctrl.res_status = thr_pkg::ST_OK;
                        n_state           = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                o_ctrl.scan_run = 1'b1;
                if (i_stat.pend) begin
                    if (i_stat.cmd == thr_pkg::CMD_APPEND) begin
                        if (i_stat.match) begin
                            o_ctrl.res_load   = 1'b1;
                            o_ctrl.res_status = thr_pkg::ST_REJECT;
                            n_state           = S_FINISH;
                        end else begin
                            n_state = S_WRITE;
                        end
                    end else if (i_stat.match) begin
                        o_ctrl.res_load   = 1'b1;
                        o_ctrl.res_found  = 1'b1;
                        o_ctrl.res_status = thr_pkg::ST_OK;
                        n_state           = S_FINISH;
                    end else if (i_stat.pend_last) begin
                        o_ctrl.res_load   = 1'b1;
                        o_ctrl.res_status = thr_pkg::ST_NOTFOUND;
                        n_state           = S_FINISH;
                    end
                end
            end
            S_WRITE: begin
                o_ctrl.write      = 1'b1;
                o_ctrl.res_load   = 1'b1;
                o_ctrl.res_status = thr_pkg::ST_OK;
                n_state           = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

`default_nettype wire
